>>> hdl/sjfs_pkg.sv
// shared types and constants for the nonpreemptive sjf / priority scheduler
`timescale 1ns / 1ps
package sjfs_pkg;

  localparam int ID_W          = 8;
  localparam int ARR_W         = 16;
  localparam int BURST_W       = 16;
  localparam int PRIO_W        = 8;
  localparam int KEY_W         = 16;
  localparam int CLK_W         = 23;
  localparam int WAIT_W        = 29;
  localparam int MAX_PROCS_DEF = 32;

  localparam logic [CLK_W-1:0]  CLOCK_MAX = {CLK_W{1'b1}};
  localparam logic [WAIT_W-1:0] WAIT_MAX  = {WAIT_W{1'b1}};

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DISPATCH,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
  } entry_t;

  typedef struct packed {
    logic               found;
    logic               any;
    logic [ID_W-1:0]    id;
    logic [ARR_W-1:0]   arr;
    logic [BURST_W-1:0] burst;
  } pick_t;

endpackage

>>> hdl/sjfs_if.sv
// channel interfaces: job load, configuration write and dispatch result
`timescale 1ns / 1ps
interface sjfs_job_if;
  logic                         valid;
  logic                         ready;
  logic [sjfs_pkg::ID_W-1:0]    job_id;
  logic [sjfs_pkg::ARR_W-1:0]   arrival_time;
  logic [sjfs_pkg::BURST_W-1:0] burst_length;
  logic [sjfs_pkg::PRIO_W-1:0]  priority_level;
  logic                         last_job;

  modport source (
    output valid, job_id, arrival_time, burst_length, priority_level, last_job,
    input  ready
  );
  modport sink (
    input  valid, job_id, arrival_time, burst_length, priority_level, last_job,
    output ready
  );
endinterface

interface sjfs_cfg_if;
  logic valid;
  logic ready;
  logic key_mode;

  modport source (output valid, key_mode, input ready);
  modport sink (input valid, key_mode, output ready);
endinterface

interface sjfs_res_if;
  logic                        valid;
  logic                        ready;
  logic [sjfs_pkg::ID_W-1:0]   sched_job_id;
  logic [sjfs_pkg::CLK_W-1:0]  start_time;
  logic [sjfs_pkg::WAIT_W-1:0] total_wait;
  logic                        last_result;

  modport source (
    output valid, sched_job_id, start_time, total_wait, last_result,
    input  ready
  );
  modport sink (
    input  valid, sched_job_id, start_time, total_wait, last_result,
    output ready
  );
endinterface

>>> hdl/sjfs_pick.sv
// shared compare unit: tracks best arrived job and earliest-arrival fallback over a scan
`timescale 1ns / 1ps
module sjfs_pick #(
  parameter int AW = 5
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       clr,
  input  logic                       en,
  input  sjfs_pkg::entry_t           ent,
  input  logic                       ent_done,
  input  logic [AW-1:0]              ent_idx,
  input  logic [sjfs_pkg::CLK_W-1:0] sim_clock,
  input  logic                       key_mode,
  output sjfs_pkg::pick_t            sel,
  output logic [AW-1:0]              sel_idx
);

  logic                           found;
  logic                           any;
  logic [sjfs_pkg::KEY_W-1:0]     b_key;
  logic [AW-1:0]                  b_idx;
  sjfs_pkg::entry_t               b_ent;
  logic [sjfs_pkg::KEY_W-1:0]     f_key;
  logic [AW-1:0]                  f_idx;
  sjfs_pkg::entry_t               f_ent;

  logic [sjfs_pkg::KEY_W-1:0]     key;
  logic                           arrived;
  logic                           take_b;
  logic                           take_f;

  always_comb begin
    key     = key_mode ? sjfs_pkg::KEY_W'(ent.prio) : ent.burst;
    arrived = sjfs_pkg::CLK_W'(ent.arrival) <= sim_clock;
    take_b  = en && !ent_done && arrived && (!found || key < b_key);
    take_f  = en && !ent_done &&
              (!any || ent.arrival < f_ent.arrival ||
               (ent.arrival == f_ent.arrival && key < f_key));
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      found <= 1'b0;
      any   <= 1'b0;
    end else begin
      if (take_b) found <= 1'b1;
      if (take_f) any <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take_b) begin
      b_key <= key;
      b_idx <= ent_idx;
      b_ent <= ent;
    end
    if (take_f) begin
      f_key <= key;
      f_idx <= ent_idx;
      f_ent <= ent;
    end
  end

  // arrived winner first, else the earliest unfinished arrival
  always_comb begin
    sel.found = found;
    sel.any   = any;
    if (found) begin
      sel.id    = b_ent.id;
      sel.arr   = b_ent.arrival;
      sel.burst = b_ent.burst;
      sel_idx   = b_idx;
    end else begin
      sel.id    = f_ent.id;
      sel.arr   = f_ent.arrival;
      sel.burst = f_ent.burst;
      sel_idx   = f_idx;
    end
  end

endmodule

>>> hdl/nonpreemptive_sjf_priority_scheduler.sv
// top level of the nonpreemptive shortest-job-first / priority scheduler
// Usage:
//   job: valid/ready sink; one word loads one job (id, arrival, burst, priority)
//     into a table of MAX_PROCS entries. Jobs beyond a full table are
//     dropped. The word with last_job set loads its job and starts the schedule.
//   cfg: write channel for key_mode (0 shortest burst, 1 lowest priority value),
//     always ready; write it only while no schedule is running.
//   res: valid/ready source; one word per loaded job in dispatch order, with
//     total_wait and last_result set on the final word.
// Scan: each dispatch scans the N loaded entries through the table memory
//   read port and one shared compare unit. job.ready is low for the whole
//   schedule.
// Stall: a held result word blocks the next result word until it is taken; the
//   last word may still wait while loading of the next set goes on.
// Reset: clears job count, done flags, clock, wait sum, key_mode and all
//   handshakes; table contents are left as they are.
`timescale 1ns / 1ps
module nonpreemptive_sjf_priority_scheduler #(
  parameter int MAX_PROCS = sjfs_pkg::MAX_PROCS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  sjfs_job_if.sink   job,
  sjfs_cfg_if.sink   cfg,
  sjfs_res_if.source res
);

  localparam int AW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CW = $clog2(MAX_PROCS + 1);
  localparam int CLK_W  = sjfs_pkg::CLK_W;
  localparam int WAIT_W = sjfs_pkg::WAIT_W;

  sjfs_pkg::state_t state;
  sjfs_pkg::state_t state_next;

  sjfs_pkg::entry_t mem [MAX_PROCS];
  sjfs_pkg::entry_t rd_data;
  sjfs_pkg::entry_t wr_data;
  logic             rd_done;
  logic             rv;
  logic [AW-1:0]    rd_idx_q;

  logic [CW-1:0]        job_count;
  logic [CW-1:0]        rd_idx;
  logic [CW-1:0]        round;
  logic [MAX_PROCS-1:0] done;
  logic                 key_mode;
  logic [CLK_W-1:0]     sim_clock;
  logic [WAIT_W-1:0]    wait_sum;

  logic [sjfs_pkg::ID_W-1:0] id_r;
  logic [CLK_W-1:0]          start_r;
  logic [CLK_W-1:0]          diff_r;

  sjfs_pkg::pick_t psel;
  logic [AW-1:0]   pick_idx;

  logic              job_acc;
  logic              load_en;
  logic              issue;
  logic              pick_clr;
  logic              out_free;
  logic              emit_go;
  logic              is_last;
  logic              end_run;
  logic [CLK_W-1:0]  start;
  logic [CLK_W-1:0]  diff;
  logic [CLK_W:0]    clk_sum;
  logic [CLK_W-1:0]  clock_next;
  logic [WAIT_W:0]   wait_add;
  logic [WAIT_W-1:0] wait_next;

  assign cfg.ready = 1'b1;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      sjfs_pkg::ST_LOAD: begin
        if (job.valid && job.last_job) state_next = sjfs_pkg::ST_SCAN;
      end
      sjfs_pkg::ST_SCAN: begin
        if (!issue && !rv) state_next = sjfs_pkg::ST_DISPATCH;
      end
      sjfs_pkg::ST_DISPATCH: begin
        state_next = sjfs_pkg::ST_EMIT;
      end
      sjfs_pkg::ST_EMIT: begin
        if (out_free) state_next = is_last ? sjfs_pkg::ST_LOAD : sjfs_pkg::ST_SCAN;
      end
      default: state_next = sjfs_pkg::ST_LOAD;
    endcase
  end

  // control outputs
  always_comb begin
    job.ready = (state == sjfs_pkg::ST_LOAD);
    issue     = (state == sjfs_pkg::ST_SCAN) && (rd_idx < job_count);
    pick_clr  = (state == sjfs_pkg::ST_DISPATCH);
    job_acc   = job.valid && job.ready;
    load_en   = job_acc && (job_count < CW'(MAX_PROCS));
    out_free  = !res.valid || res.ready;
    is_last   = (round + CW'(1)) == job_count;
    emit_go   = (state == sjfs_pkg::ST_EMIT) && out_free;
    end_run   = emit_go && is_last;
  end

  // dispatch and wait arithmetic
  always_comb begin
    start      = psel.found ? sim_clock : CLK_W'(psel.arr);
    diff       = start - CLK_W'(psel.arr);
    clk_sum    = {1'b0, start} + (CLK_W + 1)'(psel.burst);
    clock_next = clk_sum[CLK_W] ? sjfs_pkg::CLOCK_MAX : clk_sum[CLK_W-1:0];
    wait_add   = {1'b0, wait_sum} + (WAIT_W + 1)'(diff_r);
    wait_next  = wait_add[WAIT_W] ? sjfs_pkg::WAIT_MAX : wait_add[WAIT_W-1:0];
    wr_data.id      = job.job_id;
    wr_data.arrival = job.arrival_time;
    wr_data.burst   = job.burst_length;
    wr_data.prio    = job.priority_level;
  end

  sjfs_pick #(
    .AW (AW)
  ) u_pick (
    .clk       (clk),
    .rst       (rst),
    .clr       (pick_clr),
    .en        (rv),
    .ent       (rd_data),
    .ent_done  (rd_done),
    .ent_idx   (rd_idx_q),
    .sim_clock (sim_clock),
    .key_mode  (key_mode),
    .sel       (psel),
    .sel_idx   (pick_idx)
  );

  // job table
  always_ff @(posedge clk) begin
    if (load_en) mem[job_count[AW-1:0]] <= wr_data;
    rd_data  <= mem[rd_idx[AW-1:0]];
    rd_done  <= done[rd_idx[AW-1:0]];
    rd_idx_q <= rd_idx[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sjfs_pkg::ST_LOAD;
      key_mode  <= 1'b0;
      job_count <= '0;
      rd_idx    <= '0;
      rv        <= 1'b0;
      round     <= '0;
      done      <= '0;
      sim_clock <= '0;
      wait_sum  <= '0;
      res.valid <= 1'b0;
    end else begin
      state <= state_next;
      rv    <= issue;
      if (cfg.valid) key_mode <= cfg.key_mode;
      if (issue) begin
        rd_idx <= rd_idx + CW'(1);
      end else if (state == sjfs_pkg::ST_DISPATCH) begin
        rd_idx <= '0;
      end
      if (state == sjfs_pkg::ST_DISPATCH) begin
        done[pick_idx] <= 1'b1;
        sim_clock      <= clock_next;
      end
      if (end_run) begin
        job_count <= '0;
        round     <= '0;
        done      <= '0;
        sim_clock <= '0;
        wait_sum  <= '0;
      end else begin
        if (load_en) job_count <= job_count + CW'(1);
        if (emit_go) begin
          round    <= round + CW'(1);
          wait_sum <= wait_next;
        end
      end
      if (emit_go) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == sjfs_pkg::ST_DISPATCH) begin
      id_r    <= psel.id;
      start_r <= start;
      diff_r  <= diff;
    end
    if (emit_go) begin
      res.sched_job_id <= id_r;
      res.start_time   <= start_r;
      res.total_wait   <= is_last ? wait_next : '0;
      res.last_result  <= is_last;
    end
  end

  a_scan_has_jobs: assert property (@(posedge clk) disable iff (rst)
    (state != sjfs_pkg::ST_LOAD) |-> (job_count != '0 && round < job_count))
    else $error("schedule running with no job left to dispatch");

  a_dispatch_has_pick: assert property (@(posedge clk) disable iff (rst)
    (state == sjfs_pkg::ST_DISPATCH) |-> psel.any)
    else $error("dispatch without an unfinished job");

  a_pick_not_done: assert property (@(posedge clk) disable iff (rst)
    (state == sjfs_pkg::ST_DISPATCH) |-> !done[pick_idx])
    else $error("dispatched job was already finished");

  a_run_clears: assert property (@(posedge clk) disable iff (rst)
    end_run |=> (job_count == '0 && done == '0 && sim_clock == '0))
    else $error("run state not cleared after final dispatch");

  a_last_word: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.last_result) |-> (state != sjfs_pkg::ST_LOAD))
    else $error("non-final result pending with schedule finished");

endmodule
